/* rtl/double_ended_queue_unit_assert.svh */
// Assertion macros for the double-ended queue RTL.
// Depends on nothing; the assertions are left out when SYNTHESIS is defined.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define DEQ_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("double-ended queue assertion failed");
`define DEQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("double-ended queue assertion failed");
`else
`define DEQ_ASSERT(lbl, clk, rstn, prop)
`define DEQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* rtl/deq_pkg.sv */
`timescale 1ns / 1ps
// Types, constants and helper functions for the double-ended queue.
// Used by deq_store and double_ended_queue_unit; depends on nothing.
package deq_pkg;

    localparam int DEPTH      = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef logic [IDX_W-1:0]             idx_t;
    typedef logic [CNT_W-1:0]             cnt_t;
    typedef logic signed [DATA_WIDTH-1:0] word_t;
    typedef logic [2:0]                   mode_t;
    typedef logic [1:0]                   status_t;

    localparam mode_t MODE_PUSH_FRONT = 3'd0;
    localparam mode_t MODE_PUSH_BACK  = 3'd1;
    localparam mode_t MODE_POP_FRONT  = 3'd2;
    localparam mode_t MODE_POP_BACK   = 3'd3;
    localparam mode_t MODE_QUERY      = 3'd4;

    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_POP_EMPTY = 2'd1;
    localparam status_t STATUS_PUSH_FULL = 2'd2;

    typedef struct packed {
        logic  we;
        idx_t  waddr;
        word_t wdata;
        logic  re;
        idx_t  raddr;
    } store_req_t;

    function automatic idx_t idx_inc(input idx_t i);
        idx_t r;
        if (i == idx_t'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = i + idx_t'(1);
        end
        return r;
    endfunction

    function automatic idx_t idx_dec(input idx_t i);
        idx_t r;
        if (i == '0)
        begin
            r = idx_t'(DEPTH - 1);
        end
        else
        begin
            r = i - idx_t'(1);
        end
        return r;
    endfunction

    function automatic word_t word_in(input logic signed [31:0] x);
        word_t w;
        w = word_t'(x);
        return w;
    endfunction

    function automatic logic signed [31:0] word_out(input word_t w);
        logic signed [63:0] ext;
        ext = 64'(w);
        return ext[31:0];
    endfunction

endpackage

/* rtl/deq_store.sv */
`timescale 1ns / 1ps
// Word store of the double-ended queue: one write port and one registered read port.
// A read of the address written in the same cycle returns the new word. Uses deq_pkg.
module deq_store
(
    input  logic                clk,
    input  deq_pkg::store_req_t req,
    output deq_pkg::word_t      rd_data
);

    deq_pkg::word_t mem [deq_pkg::DEPTH];
    deq_pkg::word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            if (req.we && (req.waddr == req.raddr))
            begin
                rd_data_reg <= req.wdata;
            end
            else
            begin
                rd_data_reg <= mem[req.raddr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/double_ended_queue_unit.sv */
`timescale 1ns / 1ps
// Double-ended queue of signed words held in a ring buffer, with one result beat per input beat.
// An input beat goes into an input register, then its result into a result register. Throughput
// is one beat per cycle while the output is not stalled by m_tready; the store's single read port,
// primed when a pop enters the input register, supplies the word that becomes the new front or back.
// Reset clears the pointers, the count and the valid flags; the store is not cleared.
// Depends on deq_pkg, deq_store and double_ended_queue_unit_assert.svh.
`include "double_ended_queue_unit_assert.svh"

module double_ended_queue_unit
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [31:0]   s_tdata,   // data_in[31:0]
    input  logic [2:0]    s_tuser,   // mode[2:0]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [111:0]  m_tdata    // popped_value[31:0], status[33:32], item_total[44:34],
                                     // is_empty[45], front_value[77:46], back_value[109:78],
                                     // zero fill[111:110]
);

    logic                   in_valid_reg;
    deq_pkg::mode_t         in_mode_reg;
    deq_pkg::word_t         in_data_reg;

    deq_pkg::idx_t          head_reg, head_next;
    deq_pkg::idx_t          tail_reg, tail_next;
    deq_pkg::cnt_t          count_reg, count_next;
    deq_pkg::word_t         front_reg, front_next;
    deq_pkg::word_t         back_reg, back_next;

    logic                   out_valid_reg;
    logic signed [31:0]     out_popped_reg;
    deq_pkg::status_t       out_status_reg;
    logic [10:0]            out_count_reg;
    logic                   out_empty_reg;
    logic signed [31:0]     out_front_reg;
    logic signed [31:0]     out_back_reg;

    deq_pkg::word_t         popped;
    deq_pkg::status_t       status;
    deq_pkg::store_req_t    store_req;
    deq_pkg::word_t         rd_data;
    deq_pkg::mode_t         s_mode;
    logic                   exec;
    logic                   in_fire;
    logic                   is_full;
    logic                   is_empty_now;
    logic                   empty_after;

    assign exec     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || exec;
    assign in_fire  = s_tvalid && s_tready;
    assign s_mode   = s_tuser;

    assign is_full      = (count_reg == deq_pkg::cnt_t'(deq_pkg::DEPTH));
    assign is_empty_now = (count_reg == '0);
    assign empty_after  = (count_next == '0);

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        front_next      = front_reg;
        back_next       = back_reg;
        popped          = '0;
        status          = deq_pkg::STATUS_OK;
        store_req.we    = 1'b0;
        store_req.waddr = tail_reg;
        store_req.wdata = in_data_reg;
        if (exec)
        begin
            case (in_mode_reg)
                deq_pkg::MODE_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        status = deq_pkg::STATUS_PUSH_FULL;
                    end
                    else
                    begin
                        head_next       = deq_pkg::idx_dec(head_reg);
                        store_req.we    = 1'b1;
                        store_req.waddr = head_next;
                        front_next      = in_data_reg;
                        if (is_empty_now)
                        begin
                            back_next = in_data_reg;
                        end
                        count_next = count_reg + deq_pkg::cnt_t'(1);
                    end
                end
                deq_pkg::MODE_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        status = deq_pkg::STATUS_PUSH_FULL;
                    end
                    else
                    begin
                        store_req.we = 1'b1;
                        tail_next    = deq_pkg::idx_inc(tail_reg);
                        back_next    = in_data_reg;
                        if (is_empty_now)
                        begin
                            front_next = in_data_reg;
                        end
                        count_next = count_reg + deq_pkg::cnt_t'(1);
                    end
                end
                deq_pkg::MODE_POP_FRONT:
                begin
                    if (is_empty_now)
                    begin
                        status = deq_pkg::STATUS_POP_EMPTY;
                    end
                    else
                    begin
                        popped     = front_reg;
                        head_next  = deq_pkg::idx_inc(head_reg);
                        front_next = rd_data;
                        count_next = count_reg - deq_pkg::cnt_t'(1);
                    end
                end
                deq_pkg::MODE_POP_BACK:
                begin
                    if (is_empty_now)
                    begin
                        status = deq_pkg::STATUS_POP_EMPTY;
                    end
                    else
                    begin
                        popped     = back_reg;
                        tail_next  = deq_pkg::idx_dec(tail_reg);
                        back_next  = rd_data;
                        count_next = count_reg - deq_pkg::cnt_t'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end

        // The read for a pop is issued as it enters the input register, against the pointers
        // that hold after the beat now executing.
        store_req.re    = 1'b0;
        store_req.raddr = deq_pkg::idx_inc(head_next);
        case (s_mode)
            deq_pkg::MODE_POP_FRONT:
            begin
                store_req.re    = in_fire;
                store_req.raddr = deq_pkg::idx_inc(head_next);
            end
            deq_pkg::MODE_POP_BACK:
            begin
                store_req.re    = in_fire;
                store_req.raddr = deq_pkg::idx_dec(deq_pkg::idx_dec(tail_next));
            end
            default:
            begin
            end
        endcase
    end

    deq_store u_store
    (
        .clk     (clk),
        .req     (store_req),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (exec)
            begin
                in_valid_reg <= 1'b0;
            end
            if (exec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_mode_reg <= s_mode;
            in_data_reg <= deq_pkg::word_in(s_tdata);
        end
        front_reg <= front_next;
        back_reg  <= back_next;
        if (exec)
        begin
            out_popped_reg <= deq_pkg::word_out(popped);
            out_status_reg <= status;
            out_count_reg  <= 11'(count_next);
            out_empty_reg  <= empty_after;
            out_front_reg  <= empty_after ? 32'sd0 : deq_pkg::word_out(front_next);
            out_back_reg   <= empty_after ? 32'sd0 : deq_pkg::word_out(back_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_back_reg, out_front_reg, out_empty_reg, out_count_reg,
                       out_status_reg, out_popped_reg};

    `DEQ_ASSERT(a_count_bound, clk, rst_n, count_reg <= deq_pkg::cnt_t'(deq_pkg::DEPTH))
    `DEQ_ASSERT(a_empty_ptrs, clk, rst_n, (count_reg != '0) || (head_reg == tail_reg))
    `DEQ_ASSERT_NEXT(a_pop_count, clk, rst_n,
        exec && (count_reg != '0)
            && ((in_mode_reg == deq_pkg::MODE_POP_FRONT)
            || (in_mode_reg == deq_pkg::MODE_POP_BACK)),
        count_reg == $past(count_reg) - deq_pkg::cnt_t'(1))
    `DEQ_ASSERT_NEXT(a_full_drop, clk, rst_n,
        exec && is_full
            && ((in_mode_reg == deq_pkg::MODE_PUSH_FRONT)
            || (in_mode_reg == deq_pkg::MODE_PUSH_BACK)),
        $stable(head_reg) && $stable(tail_reg) && $stable(count_reg))
    `DEQ_ASSERT(a_out_empty, clk, rst_n,
        !out_valid_reg || (out_empty_reg == (out_count_reg == 11'd0)))

endmodule
